@@ rtl/srp_pkg.sv @@
// Package with the controller state type of the skyline packer.
`timescale 1ns / 1ps

package srp_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_OUT_RD,
    ST_OUT_EV,
    ST_INNER,
    ST_FIT,
    ST_TRIM_CHK,
    ST_TRIM_WR,
    ST_NEW_SEG,
    ST_DONE
  } state_e;

  localparam int unsigned FieldBits = 16;
  localparam logic [FieldBits-1:0] ResetAtlas = 16'd1024;
  localparam logic CmdClear = 1'b1;

  localparam logic CfgAtlasWidth  = 1'b0;
  localparam logic CfgAtlasHeight = 1'b1;

endpackage

@@ rtl/skyline_rect_packer_top.sv @@
// Top level of the skyline rectangle packer with its segment memory and sequencer.
//
//   channel   | handshake                         | payload
//   ----------+-----------------------------------+--------------------------------------
//   s_axis    | s_axis_tvalid / s_axis_tready     | tdata {rect_height, rect_width}, tuser command
//   m_axis    | m_axis_tvalid / m_axis_tready     | tdata {pad, table_full, pos_y, pos_x, fit}
//   cfg       | cfg_valid_i / cfg_ready_o         | cfg_index_i, cfg_data_i
//
// A clear request passes through the ST_CLEAR and ST_DONE states before its result is registered.
// For a place request every segment of the segment memory, which has separate read and
// write ports, is scanned against every other one to find the fitting limit, then, if
// a position fits, two more passes check for a free slot and trim.
// After reset the ST_INIT state writes the initial full-width segment before the
// first request is taken. A stalled result holds in the output register.
`timescale 1ns / 1ps

module skyline_rect_packer_top #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] rect_width, [31:16] rect_height
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] fit, [16:1] pos_x, [32:17] pos_y,
                                      // [33] table_full, [39:34] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import srp_pkg::*;

  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SW = ((COORD_BITS > FieldBits) ? COORD_BITS : FieldBits) + 1;
  localparam logic [CW-1:0] SegCount = CW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] level;
    logic [COORD_BITS-1:0] span;
  } seg_t;

  // True if segment a comes after segment b in (level, left, index) order.
  function automatic logic seg_after(input logic [COORD_BITS-1:0] lvl_a,
                                     input logic [COORD_BITS-1:0] lft_a,
                                     input logic [IW-1:0] idx_a,
                                     input logic [COORD_BITS-1:0] lvl_b,
                                     input logic [COORD_BITS-1:0] lft_b,
                                     input logic [IW-1:0] idx_b);
    logic res;
    if (lvl_a != lvl_b) res = lvl_a > lvl_b;
    else if (lft_a != lft_b) res = lft_a > lft_b;
    else res = idx_a > idx_b;
    return res;
  endfunction

  seg_t mem [MAX_SEGMENTS];
  seg_t rdata_q;
  logic [IW-1:0] raddr;
  logic mem_we;
  logic [IW-1:0] waddr;
  seg_t wdata;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d;
  logic rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  seg_t cur_q, cur_d;
  logic [SW-1:0] lim_q, lim_d;
  logic best_found_q, best_found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [COORD_BITS-1:0] best_left_q, best_left_d, best_level_q, best_level_d;
  logic slot_found_q, slot_found_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [FieldBits-1:0] w_q, w_d, h_q, h_d;
  logic [MAX_SEGMENTS-1:0] valid_q, valid_d;
  logic res_fit_q, res_fit_d, res_full_q, res_full_d;
  logic [FieldBits-1:0] aw_q, aw_d, ah_q, ah_d;
  logic out_vld_q, out_vld_d;
  logic [39:0] out_data_q, out_data_d;

  logic [SW-1:0] rd_right, lx, rx, cur_top, cur_end;
  logic rd_hit, rd_overlap;
  logic [IW-1:0] cur_idx;

  assign cur_idx    = i_q[IW-1:0];
  assign rd_right   = SW'(rdata_q.left) + SW'(rdata_q.span);
  assign lx         = SW'(best_left_q);
  assign rx         = lx + SW'(w_q);
  assign cur_top    = SW'(rdata_q.level) + SW'(h_q);
  assign cur_end    = SW'(cur_q.left) + SW'(w_q);
  assign rd_hit     = valid_q[rd_idx_q] &&
                      ((rd_idx_q == best_idx_q) ||
                       !seg_after(rdata_q.level, rdata_q.left, rd_idx_q,
                                  best_level_q, best_left_q, best_idx_q));
  assign rd_overlap = (rd_right > lx) && (SW'(rdata_q.left) < rx);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    logic [SW-1:0] top;
    state_d      = state_q;
    cnt_d        = cnt_q;
    i_d          = i_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    cur_d        = cur_q;
    lim_d        = lim_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_left_d  = best_left_q;
    best_level_d = best_level_q;
    slot_found_d = slot_found_q;
    slot_d       = slot_q;
    w_d          = w_q;
    h_d          = h_q;
    valid_d      = valid_q;
    res_fit_d    = res_fit_q;
    res_full_d   = res_full_q;
    aw_d         = aw_q;
    ah_d         = ah_q;
    out_vld_d    = out_vld_q;
    out_data_d   = out_data_q;
    raddr        = cnt_q[IW-1:0];
    mem_we       = 1'b0;
    waddr        = '0;
    wdata        = '0;
    top          = SW'(best_level_q) + SW'(h_q);

    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAtlasWidth:  aw_d = cfg_data_i;
        CfgAtlasHeight: ah_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we     = 1'b1;
        wdata.span = COORD_BITS'(SW'(ResetAtlas));
        valid_d    = MAX_SEGMENTS'(1);
        state_d    = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          w_d          = s_axis_tdata[15:0];
          h_d          = s_axis_tdata[31:16];
          res_fit_d    = 1'b0;
          res_full_d   = 1'b0;
          best_found_d = 1'b0;
          slot_found_d = 1'b0;
          i_d          = '0;
          state_d      = (s_axis_tuser == CmdClear) ? ST_CLEAR : ST_OUT_RD;
        end
      end
      ST_CLEAR: begin
        mem_we     = 1'b1;
        wdata.span = COORD_BITS'(SW'(aw_q));
        valid_d    = MAX_SEGMENTS'(1);
        state_d    = ST_DONE;
      end
      ST_OUT_RD: begin
        raddr = cur_idx;
        if (i_q == SegCount) begin
          cnt_d   = '0;
          state_d = best_found_q ? ST_TRIM_CHK : ST_DONE;
        end else begin
          state_d = ST_OUT_EV;
        end
      end
      ST_OUT_EV: begin
        cur_d = rdata_q;
        if (valid_q[cur_idx] && (cur_top <= SW'(ah_q))) begin
          cnt_d   = '0;
          lim_d   = SW'(aw_q);
          state_d = ST_INNER;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = ST_OUT_RD;
        end
      end
      ST_INNER, ST_TRIM_CHK, ST_TRIM_WR: begin
        // Pipelined scan: issue one read a cycle, evaluate the entry in the cycle after.
        if (cnt_q != SegCount) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IW-1:0];
          cnt_d    = cnt_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (state_q == ST_INNER) begin
            if (valid_q[rd_idx_q] && (rd_idx_q != cur_idx) &&
                seg_after(rdata_q.level, rdata_q.left, rd_idx_q,
                          cur_q.level, cur_q.left, cur_idx) &&
                (rdata_q.left > cur_q.left) && (SW'(rdata_q.left) < lim_q)) begin
              lim_d = SW'(rdata_q.left);
            end
          end else if (state_q == ST_TRIM_CHK) begin
            if ((!valid_q[rd_idx_q] || (rd_hit && rd_overlap && rd_right <= rx)) &&
                !slot_found_q) begin
              slot_found_d = 1'b1;
              slot_d       = rd_idx_q;
            end
          end else if (rd_hit && rd_overlap) begin
            if (rd_right <= rx) begin
              valid_d[rd_idx_q] = 1'b0;
            end else begin
              mem_we      = 1'b1;
              waddr       = rd_idx_q;
              wdata.left  = COORD_BITS'(rx);
              wdata.level = rdata_q.level;
              wdata.span  = COORD_BITS'(rd_right - rx);
            end
          end
        end
        if (cnt_q == SegCount && !rd_vld_q) begin
          cnt_d = '0;
          unique case (state_q)
            ST_INNER:    state_d = ST_FIT;
            ST_TRIM_CHK: begin
              if (slot_found_q) begin
                state_d = ST_TRIM_WR;
              end else begin
                res_full_d = 1'b1;
                state_d    = ST_DONE;
              end
            end
            default:     state_d = ST_NEW_SEG;
          endcase
        end
      end
      ST_FIT: begin
        if ((cur_end <= lim_q) &&
            (!best_found_q || seg_after(best_level_q, best_left_q, best_idx_q,
                                        cur_q.level, cur_q.left, cur_idx))) begin
          best_found_d = 1'b1;
          best_idx_d   = cur_idx;
          best_left_d  = cur_q.left;
          best_level_d = cur_q.level;
        end
        i_d     = i_q + CW'(1);
        state_d = ST_OUT_RD;
      end
      ST_NEW_SEG: begin
        mem_we          = 1'b1;
        waddr           = slot_q;
        wdata.left      = best_left_q;
        wdata.level     = COORD_BITS'(top);
        wdata.span      = COORD_BITS'(SW'(w_q));
        valid_d[slot_q] = 1'b1;
        res_fit_d       = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = '0;
          out_data_d[0]  = res_fit_q;
          out_data_d[33] = res_full_q;
          if (res_fit_q) begin
            out_data_d[16:1]  = FieldBits'(SW'(best_left_q));
            out_data_d[32:17] = FieldBits'(SW'(best_level_q));
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      i_q          <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      slot_found_q <= 1'b0;
      valid_q      <= MAX_SEGMENTS'(1);
      res_fit_q    <= 1'b0;
      res_full_q   <= 1'b0;
      aw_q         <= ResetAtlas;
      ah_q         <= ResetAtlas;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      i_q          <= i_d;
      rd_vld_q     <= rd_vld_d;
      best_found_q <= best_found_d;
      slot_found_q <= slot_found_d;
      valid_q      <= valid_d;
      res_fit_q    <= res_fit_d;
      res_full_q   <= res_full_d;
      aw_q         <= aw_d;
      ah_q         <= ah_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    cur_q        <= cur_d;
    lim_q        <= lim_d;
    best_idx_q   <= best_idx_d;
    best_left_q  <= best_left_d;
    best_level_q <= best_level_d;
    slot_q       <= slot_d;
    w_q          <= w_d;
    h_q          <= h_d;
    out_data_q   <= out_data_d;
  end

endmodule

@@ rtl/srp_checker.sv @@
// Port-level checker for the skyline packer and its bind to the top level.
`timescale 1ns / 1ps

module srp_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A placed rectangle is never also refused for a full table.
  a_fit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[33])
    else $error("fit and table_full both set");

  // Without a placement the position reads as zero.
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("position set without a fit");

endmodule

bind skyline_rect_packer_top srp_props u_srp_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
